FILE: design/rset_pkg.sv
package rset_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int STEP_W   = $clog2(VAL_W + 1);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_PICK   = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_PRESENCE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [1:0]              command;
        logic signed [VAL_W-1:0] value;
        logic [VAL_W-1:0]        random_word;
    } t_in;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] picked_value;
    } t_out;

    typedef enum logic [1:0] {
        RD_SEARCH,
        RD_LAST,
        RD_PICK
    } t_rd_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_MV_RD,
        S_MV_WR,
        S_DIV,
        S_PK_RD,
        S_PK_WAIT,
        S_RESP
    } t_state;

    typedef struct packed {
        logic       load;
        logic       srch_step;
        logic       div_step;
        t_rd_sel    rd_sel;
        logic       ins_wr;
        logic       mv_wr;
        logic       st_load;
        logic [1:0] status;
        logic       pick_load;
        logic       out_load;
    } t_dp_ctrl;

    typedef struct packed {
        logic [1:0] cmd;
        logic       srch_done;
        logic       found;
        logic       full;
        logic       empty;
        logic       div_done;
        logic       out_busy;
    } t_dp_stat;

endpackage

FILE: design/rset_ram.sv
module rset_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/rset_dp.sv
module rset_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rset_pkg::t_in     i_in,
    input  rset_pkg::t_dp_ctrl i_ctrl,
    output rset_pkg::t_dp_stat o_stat,
    output logic              o_valid,
    output rset_pkg::t_out    o_out,
    input  logic              i_ready
);
    import rset_pkg::*;

    logic [1:0]       r_cmd;
    logic [VAL_W-1:0] r_val;
    logic [VAL_W-1:0] r_rnd;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx;
    logic             r_pend;
    logic [IDX_W-1:0] r_pend_idx;
    logic             r_found;
    logic [IDX_W-1:0] r_found_idx;
    logic [CNT_W-1:0] r_rem;
    logic [STEP_W-1:0] r_steps;
    logic [1:0]       r_status;
    logic [VAL_W-1:0] r_pick;
    logic             r_out_valid;
    t_out             r_out;

    logic [VAL_W-1:0] rd_data;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic [CNT_W-1:0] last_idx;
    logic             hit;
    logic [CNT_W:0]   rem_sh;
    logic [CNT_W:0]   rem_sub;

    assign last_idx = r_count - CNT_W'(1);
    assign hit      = r_pend && (rd_data == r_val);
    assign rem_sh   = {r_rem, r_rnd[VAL_W-1]};
    assign rem_sub  = rem_sh - {1'b0, r_count};

    always_comb begin
        case (i_ctrl.rd_sel)
            RD_LAST: rd_addr = last_idx[IDX_W-1:0];
            RD_PICK: rd_addr = r_rem[IDX_W-1:0];
            default: rd_addr = r_idx[IDX_W-1:0];
        endcase
        wr_en   = i_ctrl.ins_wr || i_ctrl.mv_wr;
        wr_addr = i_ctrl.mv_wr ? r_found_idx : r_count[IDX_W-1:0];
        wr_data = i_ctrl.mv_wr ? rd_data : r_val;
        n_count = r_count;
        if (i_ctrl.ins_wr) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_ctrl.mv_wr) begin
            n_count = last_idx;
        end
    end

    rset_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_ctrl.load) begin
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end else if (i_ctrl.srch_step && !r_found) begin
                r_pend <= (r_idx < r_count) && !hit;
                if (hit) begin
                    r_found <= 1'b1;
                end
            end
            if (i_ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd    <= i_in.command;
            r_val    <= i_in.value;
            r_rnd    <= i_in.random_word;
            r_idx    <= '0;
            r_rem    <= '0;
            r_steps  <= '0;
            r_status <= ST_DONE;
            r_pick   <= '0;
        end else begin
            if (i_ctrl.srch_step && !r_found) begin
                r_pend_idx <= r_idx[IDX_W-1:0];
                if (r_idx < r_count) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
                if (hit) begin
                    r_found_idx <= r_pend_idx;
                end
            end
            if (i_ctrl.div_step) begin
                r_rnd   <= {r_rnd[VAL_W-2:0], 1'b0};
                r_steps <= r_steps + STEP_W'(1);
                if (rem_sh >= {1'b0, r_count}) begin
                    r_rem <= rem_sub[CNT_W-1:0];
                end else begin
                    r_rem <= rem_sh[CNT_W-1:0];
                end
            end
            if (i_ctrl.st_load) begin
                r_status <= i_ctrl.status;
            end
            if (i_ctrl.pick_load) begin
                r_pick <= rd_data;
            end
        end
        if (i_ctrl.out_load) begin
            r_out.status       <= r_status;
            r_out.picked_value <= r_pick;
        end
    end

    assign o_stat.cmd       = r_cmd;
    assign o_stat.srch_done = r_found || (!r_pend && (r_idx >= r_count));
    assign o_stat.found     = r_found;
    assign o_stat.full      = (r_count >= CNT_W'(CAPACITY));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.div_done  = (r_steps == STEP_W'(VAL_W));
    assign o_stat.out_busy  = r_out_valid && !i_ready;

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

FILE: design/rset_ctrl.sv
module rset_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_cmd,
    input  rset_pkg::t_dp_stat i_stat,
    output rset_pkg::t_dp_ctrl o_ctrl
);
    import rset_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_ctrl  = '0;
        o_ctrl.rd_sel = RD_SEARCH;
        o_ctrl.status = ST_DONE;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctrl.load = 1'b1;
                    case (i_cmd)
                        CMD_INSERT, CMD_REMOVE: n_state = S_SEARCH;
                        CMD_PICK:               n_state = S_DIV;
                        default:                n_state = S_RESP;
                    endcase
                end
            end
            S_SEARCH: begin
                o_ctrl.srch_step = 1'b1;
                if (i_stat.srch_done) begin
                    n_state = S_RESP;
                    if (i_stat.cmd == CMD_INSERT) begin
                        if (i_stat.found) begin
                            o_ctrl.st_load = 1'b1;
                            o_ctrl.status  = ST_PRESENCE;
                        end else if (i_stat.full) begin
                            o_ctrl.st_load = 1'b1;
                            o_ctrl.status  = ST_FULL;
                        end else begin
                            o_ctrl.ins_wr = 1'b1;
                        end
                    end else if (i_stat.found) begin
                        n_state = S_MV_RD;
                    end else begin
                        o_ctrl.st_load = 1'b1;
                        o_ctrl.status  = ST_PRESENCE;
                    end
                end
            end
            S_MV_RD: begin
                o_ctrl.rd_sel = RD_LAST;
                n_state       = S_MV_WR;
            end
            S_MV_WR: begin
                o_ctrl.mv_wr = 1'b1;
                n_state      = S_RESP;
            end
            S_DIV: begin
                if (i_stat.empty) begin
                    o_ctrl.st_load = 1'b1;
                    o_ctrl.status  = ST_EMPTY;
                    n_state        = S_RESP;
                end else if (i_stat.div_done) begin
                    n_state = S_PK_RD;
                end else begin
                    o_ctrl.div_step = 1'b1;
                end
            end
            S_PK_RD: begin
                o_ctrl.rd_sel = RD_PICK;
                n_state       = S_PK_WAIT;
            end
            S_PK_WAIT: begin
                o_ctrl.pick_load = 1'b1;
                n_state          = S_RESP;
            end
            S_RESP: begin
                if (!i_stat.out_busy) begin
                    o_ctrl.out_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: design/randomized_set_table_top.sv
// Insert and remove scan the live entries for the value; a remove that finds it
// then moves the last entry into the freed slot. Pick runs a 32-step bit-serial
// modulo of the random word by the live count and reads that entry (on an empty
// set it reports empty instead); an unknown command goes straight to its result.
// One transaction at a time: the next is taken the cycle after the result loads.
// Reset (synchronous, active low) empties the set and drops any pending result.
module randomized_set_table_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // request channel
    input  logic           i_valid,
    output logic           o_ready,
    input  rset_pkg::t_in  i_in,
    // result channel
    output logic           o_valid,
    input  logic           i_ready,
    output rset_pkg::t_out o_out
);
    import rset_pkg::*;

    // Command and status bundles between the sequencer and the datapath.
    t_dp_ctrl ctrl;
    t_dp_stat stat;

    // Sequencer: scan, modulo and memory access steps; waits in its
    // response state only while the result register is still occupied,
    // so a new transaction may be taken while a result waits.
    rset_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_cmd   (i_in.command),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    // Datapath: entry memory, live count, scan pointer, remainder unit
    // and the result register that drives the output channel.
    // The entry memory keeps its contents over reset; only data from entries
    // below the live count is ever used.
    rset_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ctrl  (ctrl),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_out   (o_out),
        .i_ready (i_ready)
    );

endmodule
